// ===== sv/ncr_pkg.sv =====
package ncr_pkg;

    // Cache geometry
    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // Field widths
    localparam int IP_HALF_W = 64;
    localparam int MAC_W     = 48;

    // Stream widths
    localparam int S_TDATA_W = 176;
    localparam int M_TDATA_W = 56;

    // Multicast MAC derivation
    localparam logic [7:0]  IP_MCAST_BYTE    = 8'hFF;
    localparam logic [15:0] MAC_MCAST_PREFIX = 16'h3333;
    localparam logic [23:0] MAC_SNODE_PREFIX = 24'h3333FF;

    typedef enum logic {
        OP_UPDATE  = 1'b0,
        OP_RESOLVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_REFRESHED = 2'd0,
        STATUS_INSERTED  = 2'd1,
        STATUS_FULL      = 2'd2
    } status_t;

    // One request to the cache
    typedef struct packed {
        opcode_t                opcode;
        logic [IP_HALF_W-1:0]   ip_high;
        logic [IP_HALF_W-1:0]   ip_low;
        logic [MAC_W-1:0]       new_mac;
    } req_t;

    // One result from the cache
    typedef struct packed {
        logic [MAC_W-1:0]       resolved_mac;
        logic                   hit;
        status_t                update_status;
    } rsp_t;

endpackage

// ===== sv/ncr_cache.sv =====
module ncr_cache
    import ncr_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic req_en,
    input  req_t req,
    output rsp_t rsp
);

    logic [ENTRIES-1:0]   valid_reg;
    logic [ENTRIES-1:0]   valid_next;
    logic [IP_HALF_W-1:0] key_high_reg [ENTRIES];
    logic [IP_HALF_W-1:0] key_low_reg  [ENTRIES];
    logic [MAC_W-1:0]     mac_reg      [ENTRIES];

    logic [ENTRIES-1:0]   match_vec;
    logic [IDX_W-1:0]     match_idx;
    logic [IDX_W-1:0]     free_idx;
    logic                 hit;
    logic                 full;
    logic [MAC_W-1:0]     derived_mac;
    logic                 do_update;
    logic                 do_refresh;
    logic                 do_insert;

    // Parallel key compare against every valid entry
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match_vec[i] = valid_reg[i] && (key_high_reg[i] == req.ip_high)
                           && (key_low_reg[i] == req.ip_low);
        end
    end

    // Lowest matching slot and lowest free slot
    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                match_idx = IDX_W'(i);
            end
            if (!valid_reg[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit  = |match_vec;
    assign full = &valid_reg;

    // Multicast or solicited-node MAC on a miss
    assign derived_mac = (req.ip_high[IP_HALF_W-1 -: 8] == IP_MCAST_BYTE)
                       ? {MAC_MCAST_PREFIX, req.ip_low[31:0]}
                       : {MAC_SNODE_PREFIX, req.ip_low[23:0]};

    // Result
    always_comb begin
        rsp.hit = hit;
        case (req.opcode)
            OP_RESOLVE: begin
                rsp.resolved_mac  = hit ? mac_reg[match_idx] : derived_mac;
                rsp.update_status = STATUS_REFRESHED;
            end
            default: begin
                rsp.resolved_mac  = '0;
                rsp.update_status = hit  ? STATUS_REFRESHED :
                                    full ? STATUS_FULL : STATUS_INSERTED;
            end
        endcase
    end

    // Write controls
    assign do_update  = req_en && (req.opcode == OP_UPDATE);
    assign do_refresh = do_update && hit;
    assign do_insert  = do_update && !hit && !full;

    always_comb begin
        valid_next = valid_reg;
        if (do_insert) begin
            valid_next[free_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge aclk) begin
        if (do_refresh) begin
            mac_reg[match_idx] <= req.new_mac;
        end else if (do_insert) begin
            key_high_reg[free_idx] <= req.ip_high;
            key_low_reg[free_idx]  <= req.ip_low;
            mac_reg[free_idx]      <= req.new_mac;
        end
    end

`ifndef SYNTHESIS
    // An address is held in at most one entry
    assert property (@(posedge aclk) disable iff (!aresetn) $onehot0(match_vec))
        else $error("ncr_cache: address matches several entries");

    // Entries are never evicted, so a full cache stays full
    assert property (@(posedge aclk) disable iff (!aresetn) full |=> full)
        else $error("ncr_cache: full cache lost an entry");

    // An insert sets exactly one new valid bit
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> ($countones(valid_reg) == $countones($past(valid_reg)) + 1))
        else $error("ncr_cache: insert did not add one entry");
`endif

endmodule

// ===== sv/ipv6_neighbor_cache_resolver_top.sv =====
// IPv6 neighbor cache resolver.
// Input stream (s_): one item per request. s_tuser[0] is the opcode
// (0 update/insert, 1 resolve); s_tdata carries ip_high, ip_low, new_mac.
// Output stream (m_): exactly one item per request, in order, carrying
// resolved_mac, hit and update_status.
// An update refreshes the MAC of a matching entry, else inserts into the
// lowest free slot, else is dropped (status full). A resolve returns the
// cached MAC on a hit, or a derived multicast MAC on a miss.
// Each item passes through the input register, then the eight-way compare
// into the result register, before m_tvalid rises. While m_tready is high
// the block takes one item per cycle; the cache updates at the same edge that
// registers the result, so the next item already sees the new contents.
// Reset clears all valid bits and empties both pipeline registers.
// When m_tready is low the result holds in its register and one more item
// is held in the input register; s_tready then drops until the result leaves.
module ipv6_neighbor_cache_resolver_top
    import ncr_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [63:0] ip_high, [127:64] ip_low, [175:128] new_mac
    input  logic [S_TDATA_W-1:0] s_tdata,
    // [0] opcode
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [47:0] resolved_mac, [48] hit, [50:49] update_status, [55:51] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic in_valid_reg;
    logic in_valid_next;
    req_t in_req_reg;
    logic out_valid_reg;
    logic out_valid_next;
    rsp_t out_rsp_reg;
    rsp_t rsp;
    logic fire;

    // Advance when the result register is free or being drained
    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_req_reg.opcode  <= opcode_t'(s_tuser[0]);
            in_req_reg.ip_high <= s_tdata[IP_HALF_W-1:0];
            in_req_reg.ip_low  <= s_tdata[2*IP_HALF_W-1:IP_HALF_W];
            in_req_reg.new_mac <= s_tdata[2*IP_HALF_W+MAC_W-1:2*IP_HALF_W];
        end
        if (fire) begin
            out_rsp_reg <= rsp;
        end
    end

    ncr_cache u_cache (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req_en  (fire),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_rsp_reg.update_status, out_rsp_reg.hit,
                       out_rsp_reg.resolved_mac};

`ifndef SYNTHESIS
    // A resolve never reports an update status
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_req_reg.opcode == OP_RESOLVE)
        |=> (out_rsp_reg.update_status == STATUS_REFRESHED))
        else $error("top: resolve result carries update status");

    // A dropped update never reports a hit
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_rsp_reg.update_status == STATUS_FULL) |-> !out_rsp_reg.hit)
        else $error("top: full-cache drop flagged as hit");

    // Input backpressure only while a result is stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && m_tvalid && !m_tready))
        else $error("top: input stalled without output stall");

    // A stalled result is not overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(out_rsp_reg)))
        else $error("top: stalled result changed");
`endif

endmodule
